### rtl/dsdq_pkg.sv
// ---------------------------------------------------------------------------
// dsdq_pkg
// Shared types and constants of the deadline-sorted delay queue.
// ---------------------------------------------------------------------------
`default_nettype none

package dsdq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int JOB_SLOTS   = 256;

	localparam int AW     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int JOB_AW = $clog2(JOB_SLOTS);

	localparam int DL_W  = 48;
	localparam int ID_W  = 32;
	localparam int JOB_W = 8;
	localparam int DLY_W = 31;

	typedef enum logic [1:0] {
		FN_JOIN   = 2'd0,
		FN_DEQ    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NONE     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [DL_W-1:0]  deadline;
		logic [ID_W-1:0]  ident;
		logic [JOB_W-1:0] job;
	} entry_t;

endpackage

`default_nettype wire

### rtl/dsdq_ram.sv
// ---------------------------------------------------------------------------
// dsdq_ram
// Generic simple dual-port RAM, one write and one registered read port;
// a read of the address being written returns the new word.
// ---------------------------------------------------------------------------
`default_nettype none

module dsdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read with write forwarding
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/deadline_sorted_delay_queue.sv
// ---------------------------------------------------------------------------
// deadline_sorted_delay_queue
// Timer queue sorted by deadline in an entry RAM, with a job-to-id RAM.
// ---------------------------------------------------------------------------
// Full join, nop, empty dequeue and join on an empty queue finish from idle;
//   other joins move back every entry not earlier in the sorted insert.
// Dequeue: none if the front has not expired, else entries are shifted
//   forward; a stale front is likewise dropped and the next one tried. Remove:
//   searches entries by id, then shifts entries forward when found.
// One operation at a time, busy high until done; the receiver cannot stall.
//   Reset empties the queue and clears the id counter; RAMs are not cleared.
`default_nettype none

module deadline_sorted_delay_queue (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                func,
	input  wire logic [dsdq_pkg::JOB_W-1:0] job_handle,
	input  wire logic [dsdq_pkg::DLY_W-1:0] delay_ms,
	input  wire logic [dsdq_pkg::DL_W-1:0]  now_time,
	input  wire logic [dsdq_pkg::ID_W-1:0]  target_id,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [dsdq_pkg::JOB_W-1:0]     job_out,
	output logic [dsdq_pkg::ID_W-1:0]      assigned_id
);
	import dsdq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_JCMP, S_JPUT0, S_DHEAD, S_DJOB, S_RCMP, S_SHISS, S_SHMOV
	} state_t;

	state_t            state_q, state_d;
	func_t             func_q, func_d;
	logic [JOB_W-1:0]  job_q, job_d;
	logic [DL_W-1:0]   dl_q, dl_d, now_q, now_d;
	logic [ID_W-1:0]   target_q, target_d, id_q, id_d, next_id_q, next_id_d;
	logic [ID_W-1:0]   pop_id_q, pop_id_d;
	logic [JOB_W-1:0]  pop_job_q, pop_job_d;
	logic              live_q, live_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              done_d;
	status_t           status_q, status_d;
	logic [JOB_W-1:0]  job_out_q, job_out_d;
	logic [ID_W-1:0]   assigned_q, assigned_d;

	// entry RAM and job id RAM ports
	logic              e_we;
	logic [AW-1:0]     e_waddr, e_raddr;
	entry_t            e_wdata, e_rdata, new_entry;
	logic              j_we;
	logic [JOB_AW-1:0] j_waddr, j_raddr;
	logic [ID_W-1:0]   j_wdata, j_rdata;

	logic [CNT_W:0]    idx_p1, idx_p2, cnt_w;
	logic [DL_W-1:0]   in_dl;

	dsdq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	dsdq_ram #(.WIDTH(ID_W), .DEPTH(JOB_SLOTS)) u_job_ram (
		.clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
		.raddr(j_raddr), .rdata(j_rdata)
	);

	assign idx_p1    = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);
	assign idx_p2    = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);
	assign cnt_w     = (CNT_W+1)'(cnt_q);
	assign in_dl     = now_time + DL_W'(delay_ms);
	assign new_entry = '{deadline: dl_q, ident: id_q, job: job_q};

	// next state, RAM control and result
	always_comb begin
		state_d    = state_q;
		func_d     = func_q;
		job_d      = job_q;
		dl_d       = dl_q;
		now_d      = now_q;
		target_d   = target_q;
		id_d       = id_q;
		next_id_d  = next_id_q;
		pop_id_d   = pop_id_q;
		pop_job_d  = pop_job_q;
		live_d     = live_q;
		idx_d      = idx_q;
		cnt_d      = cnt_q;
		done_d     = 1'b0;
		status_d   = status_q;
		job_out_d  = job_out_q;
		assigned_d = assigned_q;
		e_we       = 1'b0;
		e_waddr    = idx_q;
		e_wdata    = e_rdata;
		e_raddr    = '0;
		j_we       = 1'b0;
		j_waddr    = JOB_AW'(job_handle % JOB_SLOTS);
		j_wdata    = next_id_q;
		j_raddr    = JOB_AW'(e_rdata.job % JOB_SLOTS);

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					func_d   = func_t'(func);
					job_d    = job_handle;
					now_d    = now_time;
					target_d = target_id;
					dl_d     = in_dl;
					done_d     = 1'b1;
					status_d   = ST_NONE;
					job_out_d  = '0;
					assigned_d = '0;
					unique case (func_t'(func))
						FN_JOIN: begin
							if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								status_d = ST_FULL;
							end else begin
								j_we      = 1'b1;
								id_d      = next_id_q;
								next_id_d = next_id_q + ID_W'(1);
								if (cnt_q == '0) begin
									e_we       = 1'b1;
									e_waddr    = '0;
									e_wdata    = '{deadline: in_dl, ident: next_id_q,
										job: job_handle};
									cnt_d      = cnt_q + CNT_W'(1);
									status_d   = ST_OK;
									assigned_d = next_id_q;
								end else begin
									done_d  = 1'b0;
									idx_d   = AW'(cnt_q - CNT_W'(1));
									e_raddr = AW'(cnt_q - CNT_W'(1));
									state_d = S_JCMP;
								end
							end
						end
						FN_DEQ: begin
							if (cnt_q != '0) begin
								done_d  = 1'b0;
								state_d = S_DHEAD;
							end
						end
						FN_REMOVE: begin
							if (cnt_q == '0) begin
								status_d = ST_NOTFOUND;
							end else begin
								done_d  = 1'b0;
								idx_d   = '0;
								state_d = S_RCMP;
							end
						end
						FN_NOP: begin
						end
					endcase
				end
			end

			// insert scan from the tail: move back entries not earlier
			S_JCMP: begin
				e_we    = 1'b1;
				e_waddr = AW'(idx_p1);
				if (e_rdata.deadline >= dl_q) begin
					if (idx_q == '0) begin
						state_d = S_JPUT0;
					end else begin
						idx_d   = idx_q - AW'(1);
						e_raddr = idx_q - AW'(1);
					end
				end else begin
					e_wdata    = new_entry;
					cnt_d      = cnt_q + CNT_W'(1);
					done_d     = 1'b1;
					status_d   = ST_OK;
					job_out_d  = '0;
					assigned_d = id_q;
					state_d    = S_IDLE;
				end
			end

			S_JPUT0: begin
				e_we       = 1'b1;
				e_waddr    = '0;
				e_wdata    = new_entry;
				cnt_d      = cnt_q + CNT_W'(1);
				done_d     = 1'b1;
				status_d   = ST_OK;
				job_out_d  = '0;
				assigned_d = id_q;
				state_d    = S_IDLE;
			end

			// front entry word is on the read port
			S_DHEAD: begin
				if (e_rdata.deadline > now_q) begin
					done_d     = 1'b1;
					status_d   = ST_NONE;
					job_out_d  = '0;
					assigned_d = '0;
					state_d    = S_IDLE;
				end else begin
					pop_job_d = e_rdata.job;
					pop_id_d  = e_rdata.ident;
					idx_d     = '0;
					state_d   = S_DJOB;
				end
			end

			S_DJOB: begin
				live_d  = (j_rdata == pop_id_q);
				state_d = S_SHISS;
			end

			// linear search by id in deadline order
			S_RCMP: begin
				if (e_rdata.ident == target_q) begin
					pop_job_d = e_rdata.job;
					state_d   = S_SHISS;
				end else if (idx_p1 < cnt_w) begin
					idx_d   = AW'(idx_p1);
					e_raddr = AW'(idx_p1);
				end else begin
					done_d     = 1'b1;
					status_d   = ST_NOTFOUND;
					job_out_d  = '0;
					assigned_d = '0;
					state_d    = S_IDLE;
				end
			end

			// close the gap at idx, one entry a cycle
			S_SHISS, S_SHMOV: begin
				if (state_q == S_SHMOV) begin
					e_we    = 1'b1;
					e_waddr = idx_q;
					e_wdata = e_rdata;
					idx_d   = AW'(idx_p1);
				end
				if ((state_q == S_SHISS) && (idx_p1 < cnt_w)) begin
					e_raddr = AW'(idx_p1);
					state_d = S_SHMOV;
				end else if ((state_q == S_SHMOV) && (idx_p2 < cnt_w)) begin
					e_raddr = AW'(idx_p2);
				end else begin
					cnt_d      = cnt_q - CNT_W'(1);
					assigned_d = '0;
					if (func_q == FN_REMOVE || live_q) begin
						done_d    = 1'b1;
						status_d  = ST_OK;
						job_out_d = pop_job_q;
						state_d   = S_IDLE;
					end else if (cnt_q == CNT_W'(1)) begin
						done_d    = 1'b1;
						status_d  = ST_NONE;
						job_out_d = '0;
						state_d   = S_IDLE;
					end else begin
						e_raddr = '0;
						state_d = S_DHEAD;
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			next_id_q <= '0;
			done      <= 1'b0;
			live_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			next_id_q <= next_id_d;
			done      <= done_d;
			live_q    <= (state_q == S_IDLE) ? 1'b0 : live_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		func_q     <= func_d;
		job_q      <= job_d;
		dl_q       <= dl_d;
		now_q      <= now_d;
		target_q   <= target_d;
		id_q       <= id_d;
		pop_id_q   <= pop_id_d;
		pop_job_q  <= pop_job_d;
		idx_q      <= idx_d;
		status_q   <= status_d;
		job_out_q  <= job_out_d;
		assigned_q <= assigned_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign status      = status_q;
	assign job_out     = job_out_q;
	assign assigned_id = assigned_q;

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH)) else $error("entry count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q == ST_FULL) |-> cnt_q == CNT_W'(QUEUE_DEPTH))
		else $error("full reported on non-full queue");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q != ST_OK) |-> (job_out_q == '0) && (assigned_q == '0))
		else $error("failed word carries payload");

endmodule

`default_nettype wire
